// File: rtl/pcs_pkg.sv
// Shared constants, widths and codes of the pad charge statistics block.
package pcs_pkg;

    localparam int NUM_COLUMNS  = 24;
    localparam int NUM_DILOGICS = 10;
    localparam int NUM_CHANNELS = 48;
    localparam int CHARGE_BITS  = 12;

    localparam int PAD_COUNT = NUM_COLUMNS * NUM_DILOGICS * NUM_CHANNELS;
    localparam int ADDR_W    = $clog2(PAD_COUNT);

    // Field widths of the request and result items.
    localparam int COLUMN_W  = 5;
    localparam int DILOGIC_W = 4;
    localparam int CHANNEL_W = 6;
    localparam int CHARGE_W  = 12;
    localparam int SQ_IN_W   = 2 * CHARGE_W;

    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 44;
    localparam int SQUARE_W = 56;
    localparam int ENTRY_W  = COUNT_W + SUM_W + SQUARE_W;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 136;

    // Only the low CHARGE_BITS bits of a charge take part.
    localparam logic [CHARGE_W-1:0] CHARGE_MASK =
        CHARGE_W'((64'd1 << CHARGE_BITS) - 64'd1);

    typedef enum logic {
        FUNC_ACC  = 1'b0,
        FUNC_READ = 1'b1
    } t_func;

endpackage

// File: rtl/pad_charge_statistics.sv
// Top level of the per-pad charge count, sum and sum-of-squares accumulator.
//
//   Channel   Direction  Handshake                    Contents
//   s_axis    in         s_axis_tvalid/s_axis_tready  tuser func, tdata pad address, charge
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata count, charge sum, square sum
//
// One request is accepted per cycle while s_axis_tready is high. Each pad owns one RAM word,
// read at acceptance and written back at the next edge; a request that hits the pad written
// at the previous edge takes the word from a forwarding register. A read result is valid on
// m_axis once it has passed write-back and the output register. After reset a clearing pass
// writes all PAD_COUNT (11520) words, one per cycle, with s_axis_tready low. A read reaching
// write-back while a result still waits unaccepted holds s_axis_tready low; accumulate requests never stall.
module pad_charge_statistics (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0: column[4:0], dilogic[8:5], channel[14:9], charge[26:15],
    // zero fill[31:27].
    input  logic [31:0]  s_axis_tdata,
    // Fields from bit 0: func[0] (0 accumulate, 1 read).
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0: sample_count[31:0], charge_sum[75:32], square_sum[131:76],
    // zero fill[135:132].
    output logic [135:0] m_axis_tdata
);

    localparam int AW = pcs_pkg::ADDR_W;
    localparam int CW = pcs_pkg::COUNT_W;
    localparam int SW = pcs_pkg::SUM_W;
    localparam int QW = pcs_pkg::SQUARE_W;
    localparam int EW = pcs_pkg::ENTRY_W;

    // Request fields.
    logic [pcs_pkg::COLUMN_W-1:0]  w_column;
    logic [pcs_pkg::DILOGIC_W-1:0] w_dilogic;
    logic [pcs_pkg::CHANNEL_W-1:0] w_channel;
    logic [pcs_pkg::CHARGE_W-1:0]  w_charge;
    pcs_pkg::t_func                w_func;
    logic                          w_in_range;
    logic [AW-1:0]                 w_addr;
    logic                          w_accept;

    assign w_column  = s_axis_tdata[4:0];
    assign w_dilogic = s_axis_tdata[8:5];
    assign w_channel = s_axis_tdata[14:9];
    assign w_charge  = s_axis_tdata[26:15] & pcs_pkg::CHARGE_MASK;
    assign w_func    = pcs_pkg::t_func'(s_axis_tuser[0]);

    assign w_in_range = (int'(w_column) < pcs_pkg::NUM_COLUMNS) &&
                        (int'(w_dilogic) < pcs_pkg::NUM_DILOGICS) &&
                        (int'(w_channel) < pcs_pkg::NUM_CHANNELS);

    // Linear pad index: (column * dilogics + dilogic) * channels + channel.
    always_comb begin
        logic [AW-1:0] v_row;
        v_row  = AW'(w_column) * AW'(pcs_pkg::NUM_DILOGICS) + AW'(w_dilogic);
        w_addr = v_row * AW'(pcs_pkg::NUM_CHANNELS) + AW'(w_channel);
    end

    // Clearing pass after reset.
    logic          r_clr_active;
    logic [AW-1:0] r_clr_addr;

    // Write-back stage.
    logic                         r_s1_valid;
    pcs_pkg::t_func               r_s1_func;
    logic                         r_s1_in_range;
    logic [AW-1:0]                r_s1_addr;
    logic [pcs_pkg::SQ_IN_W-1:0]  r_s1_charge;
    logic [pcs_pkg::SQ_IN_W-1:0]  r_s1_square;

    // Forwarding of the word written at the previous edge.
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [EW-1:0] r_fwd_data;

    // Output register.
    logic          r_out_valid;
    logic [EW-1:0] r_out_data;

    logic          w_stall;
    logic [EW-1:0] w_rdata;
    logic [EW-1:0] w_old;
    logic [EW-1:0] w_new;
    logic          w_s1_write;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [EW-1:0] w_ram_wdata;

    // A read in the write-back stage cannot move while the output register is full.
    assign w_stall = r_s1_valid && (r_s1_func == pcs_pkg::FUNC_READ) &&
                     r_out_valid && !m_axis_tready;

    assign s_axis_tready = !r_clr_active && !w_stall;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    pcs_ram #(
        .WIDTH (EW),
        .DEPTH (pcs_pkg::PAD_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_accept),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // The RAM returns the word as it was before a write at the same edge, so a
    // back-to-back hit on one pad takes the forwarded word.
    assign w_old = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : w_rdata;

    // Saturating update of the three statistics.
    always_comb begin
        logic [CW-1:0] v_cnt;
        logic [SW-1:0] v_sum;
        logic [QW-1:0] v_sq;
        logic [SW:0]   v_sum_add;
        logic [QW:0]   v_sq_add;
        v_cnt = w_old[CW-1:0];
        v_sum = w_old[CW+SW-1:CW];
        v_sq  = w_old[EW-1:CW+SW];
        v_sum_add = {1'b0, v_sum} + (SW+1)'(r_s1_charge);
        v_sq_add  = {1'b0, v_sq} + (QW+1)'(r_s1_square);
        if (v_cnt != {CW{1'b1}}) begin
            v_cnt = v_cnt + CW'(1);
        end
        v_sum = v_sum_add[SW] ? {SW{1'b1}} : v_sum_add[SW-1:0];
        v_sq  = v_sq_add[QW] ? {QW{1'b1}} : v_sq_add[QW-1:0];
        w_new = {v_sq, v_sum, v_cnt};
    end

    assign w_s1_write = r_s1_valid && (r_s1_func == pcs_pkg::FUNC_ACC) && r_s1_in_range;

    assign w_ram_we    = r_clr_active || w_s1_write;
    assign w_ram_waddr = r_clr_active ? r_clr_addr : r_s1_addr;
    assign w_ram_wdata = r_clr_active ? '0 : w_new;

    // Clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == AW'(pcs_pkg::PAD_COUNT - 1)) begin
                r_clr_active <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Write-back stage; the square is formed on the way in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!w_stall) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_func     <= w_func;
            r_s1_in_range <= w_in_range;
            r_s1_addr     <= w_addr;
            r_s1_charge   <= pcs_pkg::SQ_IN_W'(w_charge);
            r_s1_square   <= pcs_pkg::SQ_IN_W'(w_charge) * pcs_pkg::SQ_IN_W'(w_charge);
        end
    end

    // The forwarding register holds while stalled, since the stalled read's RAM
    // data is held as well.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (!w_stall) begin
            r_fwd_valid <= w_s1_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_write) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= w_new;
        end
    end

    // Output register; an out-of-range read returns all zeros.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && (r_s1_func == pcs_pkg::FUNC_READ) && !w_stall) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && (r_s1_func == pcs_pkg::FUNC_READ) && !w_stall) begin
            r_out_data <= r_s1_in_range ? w_old : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(pcs_pkg::OUT_DATA_W - EW)'(0), r_out_data};

endmodule

// File: rtl/pcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/pad_charge_statistics_tb.sv
// Self-checking testbench of the pad charge statistics block, with its own model of the pad stores.
module pad_charge_statistics_tb;

    // Cycles without any accepted request or result before the run is declared hung.
    // The limit covers the clearing pass after reset, which writes all PAD_COUNT words.
    localparam int HANG_LIMIT = 4 * pcs_pkg::PAD_COUNT;
    // Cycles allowed after the last result for the pipeline to settle.
    localparam int TAIL_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1900;
    localparam int HOT_PADS = 8;
    localparam int LAST_COLUMN = pcs_pkg::NUM_COLUMNS - 1;
    localparam int LAST_DILOGIC = pcs_pkg::NUM_DILOGICS - 1;
    localparam int LAST_CHANNEL = pcs_pkg::NUM_CHANNELS - 1;

    typedef struct {
        pcs_pkg::t_func                func;
        logic [pcs_pkg::COLUMN_W-1:0]  column;
        logic [pcs_pkg::DILOGIC_W-1:0] dilogic;
        logic [pcs_pkg::CHANNEL_W-1:0] channel;
        logic [pcs_pkg::CHARGE_W-1:0]  charge;
        bit                            drain;    // hold this request until all results are back
    } t_pad_request;

    typedef struct {
        logic [pcs_pkg::COUNT_W-1:0]  count;
        logic [pcs_pkg::SUM_W-1:0]    sum;
        logic [pcs_pkg::SQUARE_W-1:0] square;
    } t_pad_stats;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [pcs_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]                     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [pcs_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // Requests still to be sent; the head is the one on the bus while tvalid is high.
    t_pad_request pending_requests[$];
    // Statistics that read requests already accepted are due to return, oldest first.
    t_pad_stats   expected_stats[$];

    // Model copy of the three per-pad stores; they start cleared like the block's RAM.
    bit [pcs_pkg::COUNT_W-1:0]  pad_count [pcs_pkg::PAD_COUNT];
    bit [pcs_pkg::SUM_W-1:0]    pad_sum [pcs_pkg::PAD_COUNT];
    bit [pcs_pkg::SQUARE_W-1:0] pad_square [pcs_pkg::PAD_COUNT];

    int error_count = 0;
    int requests_taken = 0;
    int results_taken = 0;
    int quiet_cycles = 0;

    pad_charge_statistics dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Applies one accepted request to the model stores. An accumulate adds its sample
    // with saturation on each store separately; a read queues the pad's statistics.
    // Pads outside the configured array are never touched and read back as zero.
    function automatic void update_pad_model(input t_pad_request req);
        bit                           in_range;
        int                           pad;
        logic [pcs_pkg::CHARGE_W-1:0] sample;
        logic [pcs_pkg::SQ_IN_W-1:0]  sample_sq;
        logic [pcs_pkg::COUNT_W:0]    next_count;
        logic [pcs_pkg::SUM_W:0]      next_sum;
        logic [pcs_pkg::SQUARE_W:0]   next_square;
        t_pad_stats                   stats;
        in_range = req.column < pcs_pkg::NUM_COLUMNS && req.dilogic < pcs_pkg::NUM_DILOGICS &&
                   req.channel < pcs_pkg::NUM_CHANNELS;
        pad = (int'(req.column) * pcs_pkg::NUM_DILOGICS + int'(req.dilogic)) *
              pcs_pkg::NUM_CHANNELS + int'(req.channel);
        sample = req.charge & pcs_pkg::CHARGE_MASK;
        sample_sq = pcs_pkg::SQ_IN_W'(sample) * pcs_pkg::SQ_IN_W'(sample);
        if (req.func == pcs_pkg::FUNC_ACC) begin
            if (in_range) begin
                // A carry out of the widened sum means the store would overflow.
                next_count = {1'b0, pad_count[pad]} + (pcs_pkg::COUNT_W+1)'(1);
                next_sum = {1'b0, pad_sum[pad]} + (pcs_pkg::SUM_W+1)'(sample);
                next_square = {1'b0, pad_square[pad]} + (pcs_pkg::SQUARE_W+1)'(sample_sq);
                pad_count[pad] = next_count[pcs_pkg::COUNT_W] ? '1 :
                                 next_count[pcs_pkg::COUNT_W-1:0];
                pad_sum[pad] = next_sum[pcs_pkg::SUM_W] ? '1 : next_sum[pcs_pkg::SUM_W-1:0];
                pad_square[pad] = next_square[pcs_pkg::SQUARE_W] ? '1 :
                                  next_square[pcs_pkg::SQUARE_W-1:0];
            end
        end else begin
            if (in_range) begin
                stats.count = pad_count[pad];
                stats.sum = pad_sum[pad];
                stats.square = pad_square[pad];
            end else begin
                stats = '{default: '0};
            end
            expected_stats.push_back(stats);
        end
    endfunction

    function automatic void add_request(input pcs_pkg::t_func func, input int column,
                                        input int dilogic, input int channel,
                                        input int charge, input bit drain);
        t_pad_request req;
        req.func = func;
        req.column = pcs_pkg::COLUMN_W'(column);
        req.dilogic = pcs_pkg::DILOGIC_W'(dilogic);
        req.channel = pcs_pkg::CHANNEL_W'(channel);
        req.charge = pcs_pkg::CHARGE_W'(charge);
        req.drain = drain;
        pending_requests.push_back(req);
    endfunction

    // Driver. The request at the head of the queue is shown on s_axis and held until
    // it is taken. Between requests the sender idles at random, except in one long
    // stretch, and a request marked for draining waits until no result is owed.
    always @(posedge i_clk) begin
        bit take_next;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                update_pad_model(pending_requests[0]);
                void'(pending_requests.pop_front());
                requests_taken++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                take_next = pending_requests.size() > 0;
                if (take_next && pending_requests[0].drain && expected_stats.size() > 0) begin
                    take_next = 1'b0;
                end
                if (take_next && !(requests_taken >= 500 && requests_taken < 900) &&
                    $urandom_range(99) < 33) begin
                    take_next = 1'b0;
                end
                if (take_next) begin
                    s_axis_tvalid <= 1'b1;
                    // tdata fields from bit 0: column, dilogic, channel, charge, zero fill.
                    s_axis_tdata <= pcs_pkg::IN_DATA_W'({pending_requests[0].charge,
                                                         pending_requests[0].channel,
                                                         pending_requests[0].dilogic,
                                                         pending_requests[0].column});
                    // tuser field from bit 0: func.
                    s_axis_tuser <= pending_requests[0].func;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every result taken is compared field by field with the oldest
    // expectation; the receiver stalls at random outside one long stretch.
    always @(posedge i_clk) begin
        t_pad_stats want;
        t_pad_stats got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_taken++;
            got.count = m_axis_tdata[pcs_pkg::COUNT_W-1:0];
            got.sum = m_axis_tdata[pcs_pkg::COUNT_W +: pcs_pkg::SUM_W];
            got.square = m_axis_tdata[pcs_pkg::COUNT_W+pcs_pkg::SUM_W +: pcs_pkg::SQUARE_W];
            if (expected_stats.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result count=%0d sum=%0d square=%0d", $time,
                         got.count, got.sum, got.square);
            end else begin
                want = expected_stats.pop_front();
                if (got.count !== want.count) begin
                    error_count++;
                    $display("%0t: sample_count expected %0d actual %0d", $time,
                             want.count, got.count);
                end
                if (got.sum !== want.sum) begin
                    error_count++;
                    $display("%0t: charge_sum expected %0d actual %0d", $time,
                             want.sum, got.sum);
                end
                if (got.square !== want.square) begin
                    error_count++;
                    $display("%0t: square_sum expected %0d actual %0d", $time,
                             want.square, got.square);
                end
            end
        end
        m_axis_tready <= (results_taken >= 100 && results_taken < 250) ||
                         $urandom_range(99) >= 33;
    end

    // Watchdog: the run is hung when neither side moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("pad_charge_statistics_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        int hot_column [HOT_PADS];
        int hot_dilogic [HOT_PADS];
        int hot_channel [HOT_PADS];
        int column;
        int dilogic;
        int channel;
        int charge;
        int pick;
        pcs_pkg::t_func func;

        // Directed part. A freshly cleared pad reads zero.
        add_request(pcs_pkg::FUNC_READ, 0, 0, 0, 0, 1'b0);
        // Back-to-back samples on one pad exercise the forwarding path, with the
        // largest and smallest charge.
        add_request(pcs_pkg::FUNC_ACC, 0, 0, 0, 4095, 1'b0);
        add_request(pcs_pkg::FUNC_ACC, 0, 0, 0, 0, 1'b0);
        add_request(pcs_pkg::FUNC_ACC, 0, 0, 0, 4095, 1'b0);
        add_request(pcs_pkg::FUNC_READ, 0, 0, 0, 0, 1'b0);
        // Highest valid pad, with alternating charge patterns.
        add_request(pcs_pkg::FUNC_ACC, LAST_COLUMN, LAST_DILOGIC, LAST_CHANNEL, 'hAAA, 1'b0);
        add_request(pcs_pkg::FUNC_ACC, LAST_COLUMN, LAST_DILOGIC, LAST_CHANNEL, 'h555, 1'b0);
        add_request(pcs_pkg::FUNC_READ, LAST_COLUMN, LAST_DILOGIC, LAST_CHANNEL, 0, 1'b0);
        // Addresses just beyond each dimension and at the top of each field: samples
        // there are dropped and reads return zero.
        add_request(pcs_pkg::FUNC_ACC, pcs_pkg::NUM_COLUMNS, 0, 0, 4095, 1'b0);
        add_request(pcs_pkg::FUNC_READ, pcs_pkg::NUM_COLUMNS, 0, 0, 0, 1'b0);
        add_request(pcs_pkg::FUNC_ACC, 0, pcs_pkg::NUM_DILOGICS, 0, 4095, 1'b0);
        add_request(pcs_pkg::FUNC_READ, 0, pcs_pkg::NUM_DILOGICS, 0, 0, 1'b0);
        add_request(pcs_pkg::FUNC_ACC, 0, 0, pcs_pkg::NUM_CHANNELS, 4095, 1'b0);
        add_request(pcs_pkg::FUNC_READ, 0, 0, pcs_pkg::NUM_CHANNELS, 0, 1'b0);
        add_request(pcs_pkg::FUNC_ACC, 31, 15, 63, 4095, 1'b0);
        add_request(pcs_pkg::FUNC_READ, 31, 15, 63, 4095, 1'b0);
        // Pad zero must not have been disturbed by the dropped samples. The sender
        // first waits until every result that is owed has come back.
        add_request(pcs_pkg::FUNC_READ, 0, 0, 0, 0, 1'b1);
        add_request(pcs_pkg::FUNC_READ, 0, 0, 0, 0, 1'b0);
        // Read right after a write on a different pad, then the written pad itself.
        add_request(pcs_pkg::FUNC_ACC, 1, 0, 0, 1, 1'b0);
        add_request(pcs_pkg::FUNC_READ, 0, 0, 1, 0, 1'b0);
        add_request(pcs_pkg::FUNC_READ, 1, 0, 0, 0, 1'b0);
        add_request(pcs_pkg::FUNC_READ, LAST_COLUMN, LAST_DILOGIC, LAST_CHANNEL, 0, 1'b0);

        // Random part. Most traffic goes to a few busy pads so that statistics grow
        // and repeated pads meet in the pipeline; the rest spreads over the array and
        // over addresses outside it.
        for (int i = 0; i < HOT_PADS; i++) begin
            hot_column[i] = $urandom_range(LAST_COLUMN);
            hot_dilogic[i] = $urandom_range(LAST_DILOGIC);
            hot_channel[i] = $urandom_range(LAST_CHANNEL);
        end
        column = 0;
        dilogic = 0;
        channel = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                // Same pad as the previous request.
            end else if (pick < 65) begin
                pick = $urandom_range(HOT_PADS - 1);
                column = hot_column[pick];
                dilogic = hot_dilogic[pick];
                channel = hot_channel[pick];
            end else if (pick < 88) begin
                column = $urandom_range(LAST_COLUMN);
                dilogic = $urandom_range(LAST_DILOGIC);
                channel = $urandom_range(LAST_CHANNEL);
            end else begin
                column = $urandom_range(31);
                dilogic = $urandom_range(15);
                channel = $urandom_range(63);
            end
            pick = $urandom_range(99);
            charge = pick < 8 ? 4095 : (pick < 12 ? 0 : $urandom_range(4095));
            func = $urandom_range(99) < 30 ? pcs_pkg::FUNC_READ : pcs_pkg::FUNC_ACC;
            add_request(func, column, dilogic, channel, charge, $urandom_range(199) == 0);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_requests.size() == 0);
        wait (expected_stats.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_stats.size() != 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, expected_stats.size());
        end
        if (error_count == 0) begin
            $display("pad_charge_statistics_tb: clean");
        end else begin
            $display("pad_charge_statistics_tb: errors");
        end
        $finish;
    end

endmodule

// File: pad_charge_statistics.f
rtl/pcs_pkg.sv
rtl/pcs_ram.sv
rtl/pad_charge_statistics.sv
tb/pad_charge_statistics_tb.sv
